[rtl/itbd_pkg.sv]
// Shared types, constants and helpers for the integer-to-base-digits block.
package itbd_pkg;

    localparam int VALUE_WIDTH_DEF = 31;
    localparam int RADIX_W         = 5;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 7;
    localparam int DIV_BITS        = 8;   // dividend bits retired per divider cycle

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;  // 'A'
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 4'd10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_in;    // latch value and radix, clear stack
        logic load_err;   // put the bad-radix beat into the output register
        logic div_step;   // one divider step
        logic push;       // last divider cycle of a digit: push remainder, keep quotient
        logic emit;       // pop one digit into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic radix_bad;
        logic num_zero;
        logic count_zero;
        logic count_one;
        logic out_free;
    } t_status;

    function automatic logic radix_is_bad(input logic [RADIX_W-1:0] radix);
        return (radix < RADIX_MIN) || (radix > RADIX_MAX);
    endfunction

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        if (d < DEC_DIGITS) begin
            return CHAR_ZERO + CHAR_W'(d);
        end
        return CHAR_A + CHAR_W'(d - DEC_DIGITS);
    endfunction

endpackage

[rtl/itbd_in_if.sv]
// Input channel: value to convert and target radix.
interface itbd_in_if
    import itbd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]     radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

[rtl/itbd_out_if.sv]
// Output channel: one ASCII digit per beat.
interface itbd_out_if
    import itbd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last;
    logic              bad_radix;

    modport source (output valid, output digit_char, output last, output bad_radix,
                    input ready);
    modport sink   (input valid, input digit_char, input last, input bad_radix,
                    output ready);
endinterface

[rtl/itbd_ctrl.sv]
// Conversion sequencer: accept, divide rounds, digit emission.
module itbd_ctrl
    import itbd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int NSTEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int SW     = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
    localparam logic [SW-1:0] STEP_LAST = SW'(NSTEPS - 1);

    t_state        r_state, n_state;
    logic [SW-1:0] r_step, n_step;
    logic          accept;
    logic          div_done;   // quotient hit zero after at least one digit

    assign o_in_ready = (r_state == S_IDLE) && i_status.out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign div_done   = (r_step == '0) && i_status.num_zero && !i_status.count_zero;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !i_status.radix_bad) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free && i_status.count_one) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_in  = accept;
                o_cmd.load_err = accept && i_status.radix_bad;
            end
            S_DIV: begin
                o_cmd.div_step = !div_done;
                o_cmd.push     = !div_done && (r_step == STEP_LAST);
            end
            S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (o_cmd.div_step) begin
            n_step = (r_step == STEP_LAST) ? '0 : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

[rtl/itbd_dpath.sv]
// Datapath: chunked restoring divider, digit stack, output register.
module itbd_dpath
    import itbd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [RADIX_W-1:0]     i_radix,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [CHAR_W-1:0]      o_digit_char,
    output logic                   o_last,
    output logic                   o_bad_radix
);

    localparam int NSTEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int WP     = NSTEPS * DIV_BITS;          // padded dividend width
    localparam int CW     = $clog2(VALUE_WIDTH + 1);    // digit count
    localparam int IW     = $clog2(VALUE_WIDTH);        // stack index

    logic [WP-1:0]      r_num, n_num;
    logic [RADIX_W-1:0] r_radix;
    logic [DIGIT_W-1:0] r_rem, n_rem;
    logic [CW-1:0]      r_count, count_dec;
    logic [DIGIT_W-1:0] r_stack [VALUE_WIDTH];
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic               r_bad;
    logic               out_free;

    // DIV_BITS restoring steps; quotient bits shift in at the bottom of r_num
    always_comb begin
        logic [DIV_BITS-1:0] chunk;
        logic [DIV_BITS-1:0] qbits;
        logic [DIGIT_W-1:0]  rem;
        logic [RADIX_W-1:0]  trial;
        chunk = r_num[WP-1 -: DIV_BITS];
        qbits = '0;
        rem   = r_rem;
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            trial = {rem, chunk[i]};
            if (trial >= r_radix) begin
                qbits[i] = 1'b1;
                trial    = trial - r_radix;
            end
            rem = trial[DIGIT_W-1:0];   // below radix, so fits
        end
        n_rem = rem;
        n_num = (r_num << DIV_BITS) | WP'(qbits);
    end

    assign count_dec = r_count - 1'b1;
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.radix_bad  = radix_is_bad(i_radix);
        o_status.num_zero   = (r_num == '0);
        o_status.count_zero = (r_count == '0);
        o_status.count_one  = (r_count == CW'(1));
        o_status.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_num   <= WP'(i_value);
            r_radix <= i_radix;
            r_rem   <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= n_num;
            r_rem <= i_cmd.push ? '0 : n_rem;
        end
        if (i_cmd.push) begin
            r_stack[r_count[IW-1:0]] <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load_in) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.emit) begin
            r_count <= count_dec;
        end
    end

    // output register: holds a beat while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.load_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_char <= CHAR_ZERO;
            r_last <= 1'b1;
            r_bad  <= 1'b1;
        end else if (i_cmd.emit) begin
            r_char <= digit_glyph(r_stack[count_dec[IW-1:0]]);
            r_last <= (r_count == CW'(1));
            r_bad  <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_digit_char = r_char;
    assign o_last       = r_last;
    assign o_bad_radix  = r_bad;

endmodule

[rtl/integer_to_base_digits_core.sv]
// Top level: converts an integer to ASCII digits in a radix from 2 to 16.
//
// Usage:
//   i_in  : one beat carries value (VALUE_WIDTH bits) and radix (5 bits).
//   o_out : one beat per digit, most significant first, as ASCII '0'-'9',
//           'A'-'F'; last marks the final digit of a conversion.
//   A radix outside 2..16 gives one beat: digit_char '0', last and bad_radix
//   set. A value of zero gives the single digit '0'.
// Timing (N = ceil(VALUE_WIDTH / 8)):
//   Each digit takes one pass of the shared divider over the N chunks of
//   the dividend, retiring 8 dividend bits per cycle against the 5-bit
//   radix. A zero-quotient check then ends the division, and digits pop
//   from the stack one per cycle while the output register is free (N = 4
//   at the default width).
//   A bad radix is answered in the accepting cycle; the beat shows next cycle.
// Stalls: the output register holds a beat while o_out.ready is low; popping
//   stops and i_in.ready stays low until the register can take a new beat.
//   i_in.ready is high only when idle and the output register is free.
// Reset: synchronous, active low; clears the sequencer, digit count and
//   output valid. The stack is not cleared: only pushed entries are read.
module integer_to_base_digits_core
    import itbd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itbd_in_if.sink     i_in,
    itbd_out_if.source  o_out
);

    t_cmd    cmd;
    t_status status;

    itbd_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    itbd_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_in.value),
        .i_radix      (i_in.radix),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_digit_char (o_out.digit_char),
        .o_last       (o_out.last),
        .o_bad_radix  (o_out.bad_radix)
    );

endmodule
